// File: design/assert_macros.svh
// assertion macros used by the decoder's parser module
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define RSD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rsd_pkg.sv
// types and constants for the run-length scanline decoder
// no dependencies
`default_nettype none

package rsd_pkg;

    localparam logic [15:0] MAGIC_WORD = 16'h5900;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_MAGIC  = 2'd1,
        ST_BAD_OFFSET = 2'd2,
        ST_OVERRUN    = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  fill_value;
        logic [15:0] fill_start;
        logic [15:0] fill_count;
        logic [15:0] line_index;
        logic        end_of_line;
        status_t     status;
    } span_t;

endpackage

`default_nettype wire

// File: design/rsd_in_reg.sv
// input register for the stream byte with valid/ready handshake
// no dependencies
`default_nettype none

module rsd_in_reg (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] stream_byte,
    input  wire logic       take,
    output logic            held_valid,
    output logic [7:0]      held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= stream_byte;
        end
    end

endmodule

`default_nettype wire

// File: design/rsd_parser.sv
// word assembly and scanline header/run parser, one byte per step
// depends on rsd_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rsd_parser
    import rsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  byte_in,
    input  wire logic [15:0] line_width,
    output logic             span_valid,
    output span_t            span
);

    typedef enum logic [2:0] {
        PH_MAGIC  = 3'd0,
        PH_COUNT  = 3'd1,
        PH_LINE   = 3'd2,
        PH_OFFSET = 3'd3,
        PH_COLOUR = 3'd4,
        PH_PIXELS = 3'd5,
        PH_PAD    = 3'd6
    } phase_t;

    localparam logic [16:0] COL_MAX = 17'h1FFFF;

    phase_t      phase_reg, phase_next;
    logic        biw_reg, biw_next;
    logic [7:0]  low_reg, low_next;
    logic [7:0]  colour_reg, colour_next;
    logic [14:0] runs_reg, runs_next;
    logic        pad_reg, pad_next;
    logic [15:0] line_reg, line_next;
    logic [16:0] col_reg, col_next;

    logic [15:0] word;
    logic [17:0] end_pos;
    logic [14:0] runs_dec;

    assign word     = {byte_in, low_reg};
    assign end_pos  = {1'b0, col_reg} + {2'b00, word};
    assign runs_dec = runs_reg - 15'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        biw_next    = biw_reg;
        low_next    = low_reg;
        colour_next = colour_reg;
        runs_next   = runs_reg;
        pad_next    = pad_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        span_valid  = 1'b0;
        span        = '0;
        span.line_index = line_reg;
        span.status     = ST_OK;
        if (step)
        begin
            if (!biw_reg)
            begin
                low_next = byte_in;
                biw_next = 1'b1;
            end
            else
            begin
                biw_next = 1'b0;
                case (phase_reg)
                    PH_COUNT:
                    begin
                        if (word < 16'd2)
                        begin
                            runs_next = '0;
                            pad_next  = 1'b0;
                        end
                        else
                        begin
                            runs_next = word[15:1] - 15'd1;
                            pad_next  = word[0];
                        end
                        phase_next = PH_LINE;
                    end
                    PH_LINE:
                    begin
                        line_next  = word;
                        phase_next = PH_OFFSET;
                    end
                    PH_OFFSET:
                    begin
                        if (word != 16'd0)
                        begin
                            phase_next       = PH_MAGIC;
                            span_valid       = 1'b1;
                            span.end_of_line = 1'b1;
                            span.status      = ST_BAD_OFFSET;
                        end
                        else
                        begin
                            col_next = '0;
                            if (runs_reg == '0)
                            begin
                                phase_next       = pad_reg ? PH_PAD : PH_MAGIC;
                                span_valid       = 1'b1;
                                span.end_of_line = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_COLOUR;
                            end
                        end
                    end
                    PH_COLOUR:
                    begin
                        colour_next = word[7:0];
                        phase_next  = PH_PIXELS;
                    end
                    PH_PIXELS:
                    begin
                        col_next   = end_pos[17] ? COL_MAX : end_pos[16:0];
                        runs_next  = runs_dec;
                        span_valid = 1'b1;
                        span.fill_value  = colour_reg;
                        span.fill_start  = col_reg[16] ? 16'hFFFF : col_reg[15:0];
                        span.fill_count  = word;
                        span.end_of_line = (runs_dec == '0);
                        span.status      = (end_pos > {2'b00, line_width}) ? ST_OVERRUN
                                                                           : ST_OK;
                        if (runs_dec == '0)
                        begin
                            phase_next = pad_reg ? PH_PAD : PH_MAGIC;
                        end
                        else
                        begin
                            phase_next = PH_COLOUR;
                        end
                    end
                    PH_PAD:
                    begin
                        pad_next   = 1'b0;
                        phase_next = PH_MAGIC;
                    end
                    default:
                    begin
                        if (word != MAGIC_WORD)
                        begin
                            phase_next       = PH_MAGIC;
                            span_valid       = 1'b1;
                            span.end_of_line = 1'b1;
                            span.status      = ST_BAD_MAGIC;
                        end
                        else
                        begin
                            phase_next = PH_COUNT;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC;
            biw_reg    <= 1'b0;
            low_reg    <= '0;
            colour_reg <= '0;
            runs_reg   <= '0;
            pad_reg    <= 1'b0;
            line_reg   <= '0;
            col_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            biw_reg    <= biw_next;
            low_reg    <= low_next;
            colour_reg <= colour_next;
            runs_reg   <= runs_next;
            pad_reg    <= pad_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
        end
    end

    // first byte of a word never yields a span
    `RSD_ASSERT_IMPL(a_low_byte_silent, !biw_reg, !span_valid, "span on first byte of word")
    // error spans close the line and carry no pixels
    `RSD_ASSERT_IMPL(a_error_span_shape,
        span_valid && (span.status == ST_BAD_MAGIC || span.status == ST_BAD_OFFSET),
        span.end_of_line && span.fill_count == 16'd0, "malformed error span")
    // a header error always sends the parser back to the magic word
    `RSD_ASSERT_NEXT(a_error_resync,
        span_valid && (span.status == ST_BAD_MAGIC || span.status == ST_BAD_OFFSET),
        phase_reg == PH_MAGIC && !biw_reg, "no resync after header error")

endmodule

`default_nettype wire

// File: design/rsd_out_reg.sv
// result register holding one fill span toward the consumer
// depends on rsd_pkg
`default_nettype none

module rsd_out_reg
    import rsd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load,
    input  wire span_t span_in,
    output logic       space,
    output logic       out_valid,
    input  wire logic  out_ready,
    output span_t      span_out
);

    logic  valid_reg;
    logic  valid_next;
    span_t span_reg;

    assign space     = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign span_out  = span_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            span_reg <= span_in;
        end
    end

endmodule

`default_nettype wire

// File: design/rle_scanline_decoder.sv
// top level of the run-length scanline decoder
// depends on rsd_pkg, rsd_in_reg, rsd_parser, rsd_out_reg
//
// channel   direction  handshake              payload
// input     in         in_valid / in_ready    stream_byte (two bytes per word, low first)
// output    out        out_valid / out_ready  fill_value, fill_start, fill_count,
//                                             line_index, end_of_line, status
// config    in         line_width_we          line_width_wdata
//
// one byte per clock unless the output stalls; a span loads at the step taking its last byte
// the parse step sits between the input register and the result register
// rst_n clears the parser to wait for a magic word and sets line_width to 65535
// out_ready low holds the result register, then the input register, then in_ready
`default_nettype none

module rle_scanline_decoder
    import rsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  stream_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       fill_value,
    output logic [15:0]      fill_start,
    output logic [15:0]      fill_count,
    output logic [15:0]      line_index,
    output logic             end_of_line,
    output logic [1:0]       status,
    input  wire logic        line_width_we,
    input  wire logic [15:0] line_width_wdata
);

    logic [15:0] line_width_reg;
    logic        held_valid;
    logic [7:0]  held_byte;
    logic        space;
    logic        step;
    logic        span_valid;
    span_t       span;
    span_t       span_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= 16'hFFFF;
        end
        else if (line_width_we)
        begin
            line_width_reg <= line_width_wdata;
        end
    end

    assign step = held_valid && space;

    rsd_in_reg u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .stream_byte (stream_byte),
        .take        (step),
        .held_valid  (held_valid),
        .held_byte   (held_byte)
    );

    rsd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .byte_in    (held_byte),
        .line_width (line_width_reg),
        .span_valid (span_valid),
        .span       (span)
    );

    rsd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (span_valid),
        .span_in   (span),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .span_out  (span_out)
    );

    assign fill_value  = span_out.fill_value;
    assign fill_start  = span_out.fill_start;
    assign fill_count  = span_out.fill_count;
    assign line_index  = span_out.line_index;
    assign end_of_line = span_out.end_of_line;
    assign status      = span_out.status;

endmodule

`default_nettype wire
